// ===== hw/rtl/srp_base64_encoder_core_defines.svh =====
// ---------------------------------------------------------------------------
// SRP base64 encoder core: assertion macros
// Shared concurrent assertion forms for the encoder RTL.
// ---------------------------------------------------------------------------
`ifndef SRP_BASE64_ENCODER_CORE_DEFINES_SVH
`define SRP_BASE64_ENCODER_CORE_DEFINES_SVH

// property holds at every edge outside reset
`define SRP_B64_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SRP_B64_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/srp_b64_pkg.sv =====
// ---------------------------------------------------------------------------
// SRP base64 encoder package
// Widths, constants, group descriptor type and the sextet alphabet.
// ---------------------------------------------------------------------------
package srp_b64_pkg;

   localparam int BYTE_W   = 8;
   localparam int SEXTET_W = 6;
   localparam int CHAR_W   = 7;
   localparam int HELD_W   = 16;
   localparam int GROUP_W  = 24;
   localparam int POS_W    = 2;
   localparam int CNT_W    = 3;

   localparam logic [POS_W-1:0] LEAD_ONE   = 2'd1;
   localparam logic [POS_W-1:0] LEAD_TWO   = 2'd2;
   localparam logic [POS_W-1:0] PLAIN_SIZE = 2'd3;
   localparam logic [CNT_W-1:0] MAX_CHARS  = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h37; // 'A' - 10
   localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h3d; // 'a' - 36
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2e;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2f;

   typedef struct packed {
      logic [GROUP_W-1:0] word;   // sextets left-aligned, next one on top
      logic [CNT_W-1:0]   chars;  // characters to emit, 1..4
      logic               last;   // group closes the message
   } grp_type;

   function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] sx);
      logic [CHAR_W-1:0] ext;
      ext = {1'b0, sx};
      if (sx < 6'd10) begin
         return CHAR_ZERO + ext;
      end else if (sx < 6'd36) begin
         return CHAR_UPPER + ext;
      end else if (sx < 6'd62) begin
         return CHAR_LOWER + ext;
      end else if (sx == 6'd62) begin
         return CHAR_DOT;
      end else begin
         return CHAR_SLASH;
      end
   endfunction

endpackage

// ===== hw/rtl/srp_b64_req_if.sv =====
// ---------------------------------------------------------------------------
// SRP base64 request channel
// Valid/ready channel carrying one message byte and its framing.
// ---------------------------------------------------------------------------
interface srp_b64_req_if;
   logic                             valid;
   logic                             ready;
   logic [srp_b64_pkg::BYTE_W-1:0]   data_byte;
   logic                             first_byte;
   logic [srp_b64_pkg::POS_W-1:0]    lead_count;
   logic                             last_byte;

   modport source (output valid, data_byte, first_byte, lead_count, last_byte,
                   input ready);
   modport sink   (input valid, data_byte, first_byte, lead_count, last_byte,
                   output ready);
endinterface

// ===== hw/rtl/srp_b64_rsp_if.sv =====
// ---------------------------------------------------------------------------
// SRP base64 response channel
// Valid/ready channel carrying one encoded character.
// ---------------------------------------------------------------------------
interface srp_b64_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [srp_b64_pkg::CHAR_W-1:0]   out_char;
   logic                             last_char;

   modport source (output valid, out_char, last_char, input ready);
   modport sink   (input valid, out_char, last_char, output ready);
endinterface

// ===== hw/rtl/srp_b64_pack.sv =====
// ---------------------------------------------------------------------------
// SRP base64 group packer
// Tracks group framing, holds partial bytes and builds the sextet group.
// ---------------------------------------------------------------------------
`include "srp_base64_encoder_core_defines.svh"

module srp_b64_pack (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [srp_b64_pkg::BYTE_W-1:0]    data_byte,
   input  logic                              first_byte,
   input  logic [srp_b64_pkg::POS_W-1:0]     lead_count,
   input  logic                              last_byte,
   output logic                              emit,
   output srp_b64_pkg::grp_type              grp
);

   logic [srp_b64_pkg::HELD_W-1:0]  held_ff, held_in;
   logic [srp_b64_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [srp_b64_pkg::POS_W-1:0]   size_ff, size_in;
   logic                            lead_ff, lead_in;

   logic [srp_b64_pkg::POS_W-1:0]   eff_size, eff_pos;
   logic                            eff_lead, lead_valid;
   logic [srp_b64_pkg::CNT_W-1:0]   count, cnt, size3, nsex, start;
   logic [srp_b64_pkg::GROUP_W-1:0] raw, masked, padded, aligned;
   logic [srp_b64_pkg::CNT_W-1:0]   pad_bytes;
   logic [srp_b64_pkg::SEXTET_W-1:0] sx0, sx1, sx2;

   always_comb begin
      lead_valid = (lead_count == srp_b64_pkg::LEAD_ONE) ||
                   (lead_count == srp_b64_pkg::LEAD_TWO);
      eff_size   = first_byte ? (lead_valid ? lead_count : srp_b64_pkg::PLAIN_SIZE)
                              : size_ff;
      eff_pos    = first_byte ? '0 : pos_ff;
      eff_lead   = first_byte ? lead_valid : lead_ff;

      size3 = {1'b0, eff_size};
      count = {1'b0, eff_pos} + 3'd1;
      emit  = !((count < size3) && !last_byte);
      cnt   = (count > size3) ? size3 : count;

      raw = {held_ff, data_byte};
      case (cnt)
         3'd3:    masked = raw;
         3'd2:    masked = {8'd0, raw[15:0]};
         default: masked = {16'd0, raw[7:0]};
      endcase
      pad_bytes = size3 - cnt;
      padded    = masked << {pad_bytes[1:0], 3'b000};

      case (eff_size)
         2'd1:    aligned = padded << 12;
         2'd2:    aligned = padded << 6;
         default: aligned = padded;
      endcase

      sx0  = aligned[23:18];
      sx1  = aligned[17:12];
      sx2  = aligned[11:6];
      nsex = size3 + 3'd1;

      // lead group drops leading zero sextets, keeping at least the last one
      start = '0;
      if (eff_lead && sx0 == '0 && nsex > 3'd1) begin
         start = 3'd1;
         if (sx1 == '0 && nsex > 3'd2) begin
            start = 3'd2;
            if (sx2 == '0 && nsex > 3'd3) begin
               start = 3'd3;
            end
         end
      end

      case (start)
         3'd1:    grp.word = aligned << 6;
         3'd2:    grp.word = aligned << 12;
         3'd3:    grp.word = aligned << 18;
         default: grp.word = aligned;
      endcase
      grp.chars = nsex - start;
      grp.last  = last_byte;

      held_in = held_ff;
      pos_in  = pos_ff;
      size_in = size_ff;
      lead_in = lead_ff;
      if (accept) begin
         if (emit) begin
            held_in = '0;
            pos_in  = '0;
            size_in = srp_b64_pkg::PLAIN_SIZE;
            lead_in = 1'b0;
         end else begin
            held_in = {held_ff[7:0], data_byte};
            pos_in  = count[srp_b64_pkg::POS_W-1:0];
            size_in = eff_size;
            lead_in = eff_lead;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pos_ff  <= '0;
         size_ff <= srp_b64_pkg::PLAIN_SIZE;
         lead_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
         pos_ff  <= pos_in;
         size_ff <= size_in;
         lead_ff <= lead_in;
      end
   end

   `SRP_B64_ASSERT(a_pos_in_group, clock, reset, pos_ff < size_ff, "group position past group size")
   `SRP_B64_ASSERT(a_emit_chars, clock, reset, !emit || (grp.chars != '0 && grp.chars <= srp_b64_pkg::MAX_CHARS), "emitted group has bad character count")

endmodule

// ===== hw/rtl/srp_base64_encoder_core.sv =====
// ---------------------------------------------------------------------------
// SRP base64 encoder core
// Encodes a byte stream into SRP base64 characters, one per output word.
// ---------------------------------------------------------------------------
//   channel   dir   payload                                   handshake
//   req_ch    in    data_byte, first_byte, lead_count, last_byte  valid/ready
//   rsp_ch    out   out_char, last_char                        valid/ready
//
// A byte is taken on each valid/ready handshake; a completed group is packed into the group
// register on acceptance and drains one character per cycle into the output
// register while the output is not stalled, so the character port bounds the rate.
// Bytes that complete no group are taken even while a group drains.
// Synchronous reset clears framing and both valid flags; output stalls hold.
// ---------------------------------------------------------------------------
`include "srp_base64_encoder_core_defines.svh"

module srp_base64_encoder_core (
   input  logic               clock,
   input  logic               reset,
   srp_b64_req_if.sink        req_ch,
   srp_b64_rsp_if.source      rsp_ch
);

   logic                              accept, emit, load, pop, grp_free;
   srp_b64_pkg::grp_type              grp;

   logic                              grp_valid_ff, grp_valid_in;
   logic [srp_b64_pkg::GROUP_W-1:0]   grp_word_ff, grp_word_in;
   logic [srp_b64_pkg::CNT_W-1:0]     grp_left_ff, grp_left_in;
   logic                              grp_last_ff, grp_last_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [srp_b64_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                              rsp_last_ff, rsp_last_in;

   srp_b64_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_ch.data_byte),
      .first_byte (req_ch.first_byte),
      .lead_count (req_ch.lead_count),
      .last_byte  (req_ch.last_byte),
      .emit       (emit),
      .grp        (grp)
   );

   always_comb begin
      pop      = grp_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
      grp_free = !grp_valid_ff || (pop && grp_left_ff == 3'd1);
      req_ch.ready = grp_free || !emit;
      accept   = req_ch.valid && req_ch.ready;
      load     = accept && emit;

      grp_valid_in = grp_valid_ff;
      grp_word_in  = grp_word_ff;
      grp_left_in  = grp_left_ff;
      grp_last_in  = grp_last_ff;
      if (load) begin
         grp_valid_in = 1'b1;
         grp_word_in  = grp.word;
         grp_left_in  = grp.chars;
         grp_last_in  = grp.last;
      end else if (pop) begin
         grp_valid_in = grp_left_ff != 3'd1;
         grp_word_in  = grp_word_ff << srp_b64_pkg::SEXTET_W;
         grp_left_in  = grp_left_ff - 3'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = srp_b64_pkg::sextet_char(grp_word_ff[23:18]);
         rsp_last_in  = grp_last_ff && grp_left_ff == 3'd1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      grp_word_ff <= grp_word_in;
      grp_left_ff <= grp_left_in;
      grp_last_ff <= grp_last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_char  = rsp_char_ff;
   assign rsp_ch.last_char = rsp_last_ff;

   `SRP_B64_ASSERT(a_grp_left, clock, reset, !grp_valid_ff || (grp_left_ff != '0 && grp_left_ff <= srp_b64_pkg::MAX_CHARS), "group register holds bad count")
   `SRP_B64_ASSERT(a_load_free, clock, reset, !load || grp_free, "group loaded over an undrained group")
   `SRP_B64_ASSERT_NEXT(a_drain_empty, clock, reset, pop && grp_left_ff == 3'd1 && !load, !grp_valid_ff, "group register not empty after final character")

endmodule
